>>> rtl/core/ep2cal_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the epoch-to-calendar pipeline.
package ep2cal_pkg;

	localparam int N_STG = 17;

	localparam int EP_W   = 35;
	localparam int ZONE_W = 6;
	localparam int T_W    = 37;
	localparam int Z_W    = 20;
	localparam int REM_W  = 17;
	localparam int DOE_W  = 18;

	// One load enable per pipeline stage, stage 1 at bit 1.
	typedef logic [N_STG:1] stg_en_t;

	// Day offset 719468 (days from 0000-03-01 to the epoch) in seconds.
	// Added up front so that the day number is the non-negative shifted day count.
	localparam logic [T_W-1:0] T_OFS = T_W'(64'd719468 * 64'd86400);

	// Reciprocals floor(2^S / d); quotient estimate is exact or one low.
	localparam logic [30:0] RCP_675    = 31'((64'd1 << 40) / 64'd675);
	localparam logic [17:0] RCP_3600   = 18'((64'd1 << 29) / 64'd3600);
	localparam logic [20:0] RCP_7      = 21'((64'd1 << 23) / 64'd7);
	localparam logic [12:0] RCP_60     = 13'((64'd1 << 18) / 64'd60);
	localparam logic [20:0] RCP_146097 = 21'((64'd1 << 38) / 64'd146097);
	localparam logic [18:0] RCP_1460   = 19'((64'd1 << 29) / 64'd1460);
	localparam logic [18:0] RCP_36524  = 19'((64'd1 << 34) / 64'd36524);
	localparam logic [18:0] RCP_365    = 19'((64'd1 << 27) / 64'd365);
	localparam logic [9:0]  RCP_100    = 10'((64'd1 << 16) / 64'd100);
	localparam logic [11:0] RCP_153    = 12'((64'd1 << 19) / 64'd153);
	localparam logic [11:0] RCP_5      = 12'((64'd1 << 14) / 64'd5);

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} tod_t;

	typedef struct packed {
		logic [10:0] year_since_1900;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [8:0]  day_of_year;
	} date_t;

endpackage

>>> rtl/core/ep2cal_split.sv
`timescale 1ns / 1ps
// Stages 1-3: zone offset, then split into shifted day number and second of day.
module ep2cal_split import ep2cal_pkg::*; (
	input  logic              clk,
	input  stg_en_t           en,
	input  logic [EP_W-1:0]   epoch_seconds,
	input  logic [ZONE_W-1:0] zone_hours,
	output logic [Z_W-1:0]    z_s3,
	output logic [REM_W-1:0]  rem_s3
);

	logic [T_W:0]   ep_ext;
	logic [T_W:0]   zone_sec;
	logic [T_W:0]   t_sum;
	logic [T_W-1:0] t_s1;
	logic [60:0]    dq_prod;
	logic [Z_W-1:0] dq_s2;
	logic [29:0]    dx_s2;
	logic [6:0]     lo_s2;
	logic [29:0]    dr0;
	logic           dfix;

	always_comb begin
		ep_ext   = {{(T_W + 1 - EP_W){epoch_seconds[EP_W-1]}}, epoch_seconds};
		zone_sec = {{(T_W + 1 - ZONE_W){zone_hours[ZONE_W-1]}}, zone_hours} * 38'd3600;
		t_sum    = ep_ext + zone_sec + {1'b0, T_OFS};
		// 86400 = 128 * 675: drop seven bits, divide the rest by 675
		dq_prod  = 61'(t_s1[T_W-1:7]) * 61'(RCP_675);
		dr0      = dx_s2 - 30'(dq_s2) * 30'd675;
		dfix     = dr0 >= 30'd675;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s1 <= t_sum[T_W-1:0];
		end
		if (en[2]) begin
			dq_s2 <= dq_prod[59:40];
			dx_s2 <= t_s1[T_W-1:7];
			lo_s2 <= t_s1[6:0];
		end
		if (en[3]) begin
			z_s3   <= dfix ? dq_s2 + Z_W'(1) : dq_s2;
			rem_s3 <= {(dfix ? 10'(dr0 - 30'd675) : dr0[9:0]), lo_s2};
		end
	end

endmodule

>>> rtl/core/ep2cal_tod.sv
`timescale 1ns / 1ps
// Stages 4-7: hour, minute, second and weekday, then delay to the output stage.
module ep2cal_tod import ep2cal_pkg::*; (
	input  logic             clk,
	input  stg_en_t          en,
	input  logic [Z_W-1:0]   z_s3,
	input  logic [REM_W-1:0] rem_s3,
	output tod_t             tod_out
);

	logic [34:0]      hq_prod;
	logic [Z_W-1:0]   w;
	logic [40:0]      wq_prod;
	logic [4:0]       hq_s4;
	logic [REM_W-1:0] rem_s4;
	logic [17:0]      wq_s4;
	logic [Z_W-1:0]   w_s4;
	logic [REM_W-1:0] hr0;
	logic             hfix;
	logic [Z_W-1:0]   wr0;
	logic [4:0]       hour_s5;
	logic [11:0]      sr_s5;
	logic [2:0]       wd_s5;
	logic [24:0]      mq_prod;
	logic [5:0]       mq_s6;
	logic [11:0]      sr_s6;
	logic [4:0]       hour_s6;
	logic [2:0]       wd_s6;
	logic [11:0]      mr0;
	logic             mfix;
	tod_t             tod_s7;
	tod_t             tod_s [8:N_STG];

	always_comb begin
		hq_prod = 35'(rem_s3) * 35'(RCP_3600);
		// shifted day 0 falls on a Wednesday, so weekday = (z + 3) mod 7
		w       = z_s3 + Z_W'(3);
		wq_prod = 41'(w) * 41'(RCP_7);
		hr0     = rem_s4 - REM_W'(hq_s4) * REM_W'(3600);
		hfix    = hr0 >= REM_W'(3600);
		wr0     = w_s4 - Z_W'(wq_s4) * Z_W'(7);
		mq_prod = 25'(sr_s5) * 25'(RCP_60);
		mr0     = sr_s6 - 12'(mq_s6) * 12'd60;
		mfix    = mr0 >= 12'd60;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hq_s4  <= hq_prod[33:29];
			rem_s4 <= rem_s3;
			wq_s4  <= wq_prod[40:23];
			w_s4   <= w;
		end
		if (en[5]) begin
			hour_s5 <= hq_s4 + 5'(hfix);
			sr_s5   <= hfix ? 12'(hr0 - REM_W'(3600)) : hr0[11:0];
			wd_s5   <= (wr0 >= Z_W'(7)) ? 3'(wr0 - Z_W'(7)) : wr0[2:0];
		end
		if (en[6]) begin
			mq_s6   <= mq_prod[23:18];
			sr_s6   <= sr_s5;
			hour_s6 <= hour_s5;
			wd_s6   <= wd_s5;
		end
		if (en[7]) begin
			tod_s7.hour    <= hour_s6;
			tod_s7.minute  <= mq_s6 + 6'(mfix);
			tod_s7.second  <= mfix ? 6'(mr0 - 12'd60) : mr0[5:0];
			tod_s7.weekday <= wd_s6;
		end
	end

	for (genvar k = 8; k <= N_STG; k++) begin : g_dly
		if (k == 8) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					tod_s[k] <= tod_s7;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					tod_s[k] <= tod_s[k-1];
				end
			end
		end
	end

	assign tod_out = tod_s[N_STG];

endmodule

>>> rtl/core/ep2cal_date.sv
`timescale 1ns / 1ps
// Stages 4-17: closed-form day number to year, month, day and day of year.
module ep2cal_date import ep2cal_pkg::*; (
	input  logic           clk,
	input  stg_en_t        en,
	input  logic [Z_W-1:0] z_s3,
	output date_t          date_out
);

	// era
	logic [40:0]      eq_prod;
	logic [2:0]       eq_s4;
	logic [Z_W-1:0]   z_s4;
	logic [Z_W-1:0]   er0;
	logic             efix;
	logic [2:0]       era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [DOE_W-1:0] doe_s5, doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11, doe_s12;
	// year of era
	logic [36:0]      a_prod, b_prod, y_prod;
	logic [6:0]       aq_s6, aq_s7;
	logic [2:0]       bq_s6, bq_s7;
	logic [DOE_W-1:0] ar0, br0;
	logic             last_s7;
	logic [DOE_W-1:0] n_s8, n_s9;
	logic [8:0]       yq_s9;
	logic [DOE_W-1:0] yr0;
	logic [8:0]       yoe_s10, yoe_s11;
	// day of year, leap year
	logic [18:0]      c_prod;
	logic [2:0]       cq_s11, cq_s12;
	logic [DOE_W-1:0] base_s11, base_s12;
	logic [11:0]      year_s11, year_s12, year_s13, year_s14, year_s15, year_s16;
	logic [8:0]       cr0, cent_r;
	logic             cfix;
	logic             leap_s12, leap_s13, leap_s14, leap_s15, leap_s16;
	logic [8:0]       doy_s13, doy_s14, doy_s15, doy_s16;
	// month and day
	logic [10:0]      x153, x153_s14, mr0;
	logic [22:0]      m_prod, d_prod;
	logic [3:0]       mq_s14, mp_s15, mp_s16;
	logic [10:0]      x5, x5_s16, dr0;
	logic [8:0]       dq_s16, dsum;
	logic             jan_feb;

	always_comb begin
		eq_prod = 41'(z_s3) * 41'(RCP_146097);
		er0     = z_s4 - Z_W'(eq_s4) * Z_W'(146097);
		efix    = er0 >= Z_W'(146097);
		a_prod  = 37'(doe_s5) * 37'(RCP_1460);
		b_prod  = 37'(doe_s5) * 37'(RCP_36524);
		ar0     = doe_s6 - DOE_W'(aq_s6) * DOE_W'(1460);
		br0     = doe_s6 - DOE_W'(bq_s6) * DOE_W'(36524);
		y_prod  = 37'(n_s8) * 37'(RCP_365);
		yr0     = n_s9 - DOE_W'(yq_s9) * DOE_W'(365);
		c_prod  = 19'(yoe_s10) * 19'(RCP_100);
		cr0     = yoe_s11 - 9'(cq_s11) * 9'd100;
		cfix    = cr0 >= 9'd100;
		cent_r  = cfix ? cr0 - 9'd100 : cr0;
		x153    = 11'(doy_s13) * 11'd5 + 11'd2;
		m_prod  = 23'(x153) * 23'(RCP_153);
		mr0     = x153_s14 - 11'(mq_s14) * 11'd153;
		x5      = 11'(mp_s15) * 11'd153 + 11'd2;
		d_prod  = 23'(x5) * 23'(RCP_5);
		dr0     = x5_s16 - 11'(dq_s16) * 11'd5;
		dsum    = dq_s16 + 9'(dr0 >= 11'd5);
		// the shifted year starts in March: its months 10 and 11 are January and February
		jan_feb = mp_s16 >= 4'd10;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			eq_s4 <= eq_prod[40:38];
			z_s4  <= z_s3;
		end
		if (en[5]) begin
			era_s5 <= eq_s4 + 3'(efix);
			doe_s5 <= efix ? DOE_W'(er0 - Z_W'(146097)) : er0[DOE_W-1:0];
		end
		if (en[6]) begin
			aq_s6  <= a_prod[35:29];
			bq_s6  <= b_prod[36:34];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
		if (en[7]) begin
			aq_s7   <= aq_s6 + 7'(ar0 >= DOE_W'(1460));
			bq_s7   <= bq_s6 + 3'(br0 >= DOE_W'(36524));
			last_s7 <= doe_s6 == DOE_W'(146096);
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;
		end
		if (en[8]) begin
			n_s8   <= doe_s7 - DOE_W'(aq_s7) + DOE_W'(bq_s7) - DOE_W'(last_s7);
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
		end
		if (en[9]) begin
			yq_s9  <= y_prod[35:27];
			n_s9   <= n_s8;
			doe_s9 <= doe_s8;
			era_s9 <= era_s8;
		end
		if (en[10]) begin
			yoe_s10 <= yq_s9 + 9'(yr0 >= DOE_W'(365));
			doe_s10 <= doe_s9;
			era_s10 <= era_s9;
		end
		if (en[11]) begin
			cq_s11   <= c_prod[18:16];
			base_s11 <= DOE_W'(yoe_s10) * DOE_W'(365) + DOE_W'(yoe_s10[8:2]);
			year_s11 <= 12'(era_s10) * 12'd400 + 12'(yoe_s10);
			yoe_s11  <= yoe_s10;
			doe_s11  <= doe_s10;
		end
		if (en[12]) begin
			cq_s12   <= cq_s11 + 3'(cfix);
			// year mod 400 is the year of era
			leap_s12 <= (yoe_s11[1:0] == 2'd0) && ((cent_r != 9'd0) || (yoe_s11 == 9'd0));
			base_s12 <= base_s11;
			doe_s12  <= doe_s11;
			year_s12 <= year_s11;
		end
		if (en[13]) begin
			doy_s13  <= 9'(doe_s12 - base_s12 + DOE_W'(cq_s12));
			year_s13 <= year_s12;
			leap_s13 <= leap_s12;
		end
		if (en[14]) begin
			mq_s14   <= m_prod[22:19];
			x153_s14 <= x153;
			doy_s14  <= doy_s13;
			year_s14 <= year_s13;
			leap_s14 <= leap_s13;
		end
		if (en[15]) begin
			mp_s15   <= mq_s14 + 4'(mr0 >= 11'd153);
			doy_s15  <= doy_s14;
			year_s15 <= year_s14;
			leap_s15 <= leap_s14;
		end
		if (en[16]) begin
			dq_s16   <= d_prod[22:14];
			x5_s16   <= x5;
			mp_s16   <= mp_s15;
			doy_s16  <= doy_s15;
			year_s16 <= year_s15;
			leap_s16 <= leap_s15;
		end
		if (en[17]) begin
			date_out.year_since_1900 <= 11'(year_s16 + 12'(jan_feb) - 12'd1900);
			date_out.month           <= jan_feb ? mp_s16 - 4'd10 : mp_s16 + 4'd2;
			date_out.day_of_month    <= 5'(doy_s16 - dsum + 9'd1);
			date_out.day_of_year     <= jan_feb ? doy_s16 - 9'd306
			                                    : doy_s16 + 9'd59 + 9'(leap_s16);
		end
	end

endmodule

>>> rtl/core/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// Top level: epoch seconds to Gregorian calendar fields, 17-stage pipeline.
// Usage
//   time channel: epoch_seconds (signed seconds since 1970-01-01 UTC) with
//   time_valid/time_stall. A request is taken on a rising edge with
//   time_valid high and time_stall low.
//   cal channel: year_since_1900, month, day_of_month, hour, minute, second,
//   weekday and day_of_year with cal_valid/cal_stall, same rule.
//   cfg channel: cfg_data carries the signed zone offset in whole hours,
//   written on cfg_valid with cfg_ready (always high). Write it only while
//   the pipeline is empty.
// Timing
//   17 register stages. Throughput is one request per cycle while cal_stall
//   does not hold the output, set by the pipeline of constant-reciprocal
//   multipliers (each divide is a multiply stage followed by a correct stage).
// Reset and backpressure
//   Reset empties the pipeline and sets the zone offset to +8 hours.
//   While cal_stall holds a result, the stages behind it keep moving until
//   they fill; a full stage holds while the one ahead holds, so nothing is
//   dropped or repeated. time_stall rises once stage 1 is full and held.
module epoch_seconds_to_calendar import ep2cal_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     time_valid,
	output logic                     time_stall,
	input  logic signed [EP_W-1:0]   epoch_seconds,
	output logic                     cal_valid,
	input  logic                     cal_stall,
	output logic signed [10:0]       year_since_1900,
	output logic [3:0]               month,
	output logic [4:0]               day_of_month,
	output logic [4:0]               hour,
	output logic [5:0]               minute,
	output logic [5:0]               second,
	output logic [2:0]               weekday,
	output logic [8:0]               day_of_year,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic signed [ZONE_W-1:0] cfg_data
);

	logic [ZONE_W-1:0] zone_q;
	logic [N_STG:1]    vld_q;
	stg_en_t           adv;
	logic [Z_W-1:0]    z_s3;
	logic [REM_W-1:0]  rem_s3;
	tod_t              tod_out;
	date_t             date_out;

	// Zone register: no write side effects, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			zone_q <= cfg_data;
		end
	end

	// A stage loads when it is empty or the stage ahead loads too.
	always_comb begin
		adv[N_STG] = !vld_q[N_STG] || !cal_stall;
		for (int k = N_STG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~adv) | ({vld_q[N_STG-1:1], time_valid} & adv);
		end
	end

	assign time_stall = !adv[1];
	assign cal_valid  = vld_q[N_STG];

	ep2cal_split u_split (
		.clk           (clk),
		.en            (adv),
		.epoch_seconds (epoch_seconds),
		.zone_hours    (zone_q),
		.z_s3          (z_s3),
		.rem_s3        (rem_s3)
	);

	ep2cal_tod u_tod (
		.clk     (clk),
		.en      (adv),
		.z_s3    (z_s3),
		.rem_s3  (rem_s3),
		.tod_out (tod_out)
	);

	ep2cal_date u_date (
		.clk      (clk),
		.en       (adv),
		.z_s3     (z_s3),
		.date_out (date_out)
	);

	assign year_since_1900 = date_out.year_since_1900;
	assign month           = date_out.month;
	assign day_of_month    = date_out.day_of_month;
	assign day_of_year     = date_out.day_of_year;
	assign hour            = tod_out.hour;
	assign minute          = tod_out.minute;
	assign second          = tod_out.second;
	assign weekday         = tod_out.weekday;

endmodule

>>> tb/epoch_seconds_to_calendar_tb.sv
`timescale 1ns / 1ps
// Testbench for epoch_seconds_to_calendar: randomized epoch times under zone changes and backpressure.
module epoch_seconds_to_calendar_tb;
	import ep2cal_pkg::*;

	// Long enough for ~1500 requests at heavy stall rates plus the long hold-offs.
	localparam int LIMIT_CYCLES  = 400000;
	localparam int DRAIN_CYCLES  = 40;  // pipeline is 17 deep, leave margin
	localparam int LONG_HOLD     = 400;
	localparam int ITEMS_PER_SET = 205;

	// Calendar fields as the block presents them.
	typedef struct packed {
		logic signed [10:0] year_since_1900;
		logic [3:0]         month;
		logic [4:0]         day_of_month;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [2:0]         weekday;
		logic [8:0]         day_of_year;
	} cal_fields_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     time_valid = 1'b0;
	logic                     time_stall;
	logic signed [EP_W-1:0]   epoch_seconds = '0;
	logic                     cal_valid;
	logic                     cal_stall = 1'b0;
	logic signed [10:0]       year_since_1900;
	logic [3:0]               month;
	logic [4:0]               day_of_month;
	logic [4:0]               hour;
	logic [5:0]               minute;
	logic [5:0]               second;
	logic [2:0]               weekday;
	logic [8:0]               day_of_year;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic signed [ZONE_W-1:0] cfg_data = '0;

	epoch_seconds_to_calendar dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.time_valid     (time_valid),
		.time_stall     (time_stall),
		.epoch_seconds  (epoch_seconds),
		.cal_valid      (cal_valid),
		.cal_stall      (cal_stall),
		.year_since_1900(year_since_1900),
		.month          (month),
		.day_of_month   (day_of_month),
		.hour           (hour),
		.minute         (minute),
		.second         (second),
		.weekday        (weekday),
		.day_of_year    (day_of_year),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------
	// Floor division for a positive divisor; SV '/' truncates toward zero.
	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	// Converts a local time (epoch plus zone) to broken-down Gregorian fields.
	// Day number is shifted so that eras of 400 years start on 0000-03-01;
	// the March-based year makes February the last month, so leap days
	// only ever land at the end of a year of the era.
	function automatic cal_fields_t civil_from_epoch(logic signed [EP_W-1:0] secs,
			logic signed [ZONE_W-1:0] zone);
		cal_fields_t f;
		longint t, days, sod, wd, shifted, era, doe, yoe, yr, doy, mp, mday, mon, yday;
		longint m;
		bit     leap;
		t    = longint'(secs) + longint'(zone) * 3600;
		days = floor_quot(t, 86400);
		sod  = t - days * 86400;
		wd   = (days + 4) - floor_quot(days + 4, 7) * 7;  // epoch day was a Thursday

		shifted = days + 719468;
		era  = floor_quot(shifted, 146097);
		doe  = shifted - era * 146097;
		yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		yr   = yoe + era * 400;
		doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp   = (5 * doy + 2) / 153;
		mday = doy - (153 * mp + 2) / 5 + 1;
		mon  = (mp < 10) ? mp + 2 : mp - 10;
		if (mon <= 1)
			yr++;

		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		yday = mday - 1;
		for (m = 0; m < mon; m++) begin
			if (m == 1)
				yday += leap ? 29 : 28;
			else if (m == 3 || m == 5 || m == 8 || m == 10)
				yday += 30;
			else
				yday += 31;
		end

		f.year_since_1900 = 11'(yr - 1900);
		f.month           = 4'(mon);
		f.day_of_month    = 5'(mday);
		f.hour            = 5'(sod / 3600);
		f.minute          = 6'((sod % 3600) / 60);
		f.second          = 6'(sod % 60);
		f.weekday         = 3'(wd);
		f.day_of_year     = 9'(yday);
		return f;
	endfunction

	// Random time: full 35-bit range, near midnight of a random day in local
	// time, or the 32-bit window around the epoch.
	function automatic logic signed [EP_W-1:0] pick_epoch(logic signed [ZONE_W-1:0] zone);
		longint d, t;
		int     kind;
		kind = $urandom_range(0, 9);
		if (kind < 4)
			return EP_W'({$urandom, $urandom});
		if (kind < 8) begin
			d = longint'($urandom_range(0, 397000)) - 198500;
			t = d * 86400 - longint'(zone) * 3600 + longint'($urandom_range(0, 6)) - 3;
			return EP_W'(t);
		end
		return EP_W'(longint'($signed($urandom)));
	endfunction

	// ------------------------------------------------------------------
	// Shared state
	// ------------------------------------------------------------------
	logic signed [EP_W-1:0]   pending_times[$];   // requests not yet driven
	cal_fields_t              cal_expected[$];    // predicted results, oldest first
	logic signed [ZONE_W-1:0] zone_now = 6'sd8;   // zone as the block holds it

	bit request_taken = 1'b0;
	int cycles = 0;
	int mismatches = 0;
	int times_sent = 0;
	int results_checked = 0;
	int zone_writes = 0;
	int input_stall_cycles = 0;

	int hold_asks = 0;
	int hold_done = 0;
	int long_hold_cnt = 0;

	// ------------------------------------------------------------------
	// Monitor: everything sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cal_fields_t got, exp_f;
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: timeout after %0d cycles, %0d results outstanding",
				cycles, cal_expected.size());
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				zone_now = cfg_data;
				zone_writes++;
			end
			if (time_stall)
				input_stall_cycles++;

			// Accepted request: predict with the zone in force now.
			if (time_valid && !time_stall) begin
				cal_expected.push_back(civil_from_epoch(epoch_seconds, zone_now));
				request_taken = 1'b1;
				times_sent++;
			end

			if (cal_valid && !cal_stall) begin
				got = '{year_since_1900, month, day_of_month, hour, minute, second,
					weekday, day_of_year};
				if (cal_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: result with nothing pending at cycle %0d", cycles);
				end else begin
					exp_f = cal_expected.pop_front();
					results_checked++;
					if (got.year_since_1900 !== exp_f.year_since_1900 ||
							got.month !== exp_f.month ||
							got.day_of_month !== exp_f.day_of_month ||
							got.hour !== exp_f.hour || got.minute !== exp_f.minute ||
							got.second !== exp_f.second || got.weekday !== exp_f.weekday ||
							got.day_of_year !== exp_f.day_of_year) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("tb: mismatch at cycle %0d", cycles);
							$display("  exp y%0d m%0d d%0d %0d:%0d:%0d wd%0d yd%0d",
								exp_f.year_since_1900, exp_f.month, exp_f.day_of_month,
								exp_f.hour, exp_f.minute, exp_f.second, exp_f.weekday,
								exp_f.day_of_year);
							$display("  got y%0d m%0d d%0d %0d:%0d:%0d wd%0d yd%0d",
								got.year_since_1900, got.month, got.day_of_month,
								got.hour, got.minute, got.second, got.weekday,
								got.day_of_year);
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts of requests separated by random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			// Only move on once the current request is gone.
			if (!time_valid || request_taken) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 20);
					// about a quarter of bursts run back to back
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (burst_left != 0 && pending_times.size() != 0) begin
					epoch_seconds <= pending_times.pop_front();
					time_valid <= 1'b1;
					burst_left--;
				end else begin
					time_valid <= 1'b0;
					if (burst_left == 0 && gap_left != 0)
						gap_left--;
				end
			end
			request_taken = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern changes mode after a random run of cycles
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;

	// Long hold-off, counted in its own process; overrides the pattern.
	always @(negedge clk) begin
		if (long_hold_cnt != 0)
			long_hold_cnt <= long_hold_cnt - 1;
		else if (hold_asks != hold_done) begin
			long_hold_cnt <= LONG_HOLD;
			hold_done <= hold_done + 1;
		end
	end

	always @(negedge clk) begin
		bit stall_next;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: stall_next = 1'b0;                              // free flow
			1: stall_next = ($urandom_range(0, 9) < 3);        // light
			2: stall_next = ($urandom_range(0, 9) < 7);        // heavy
			default: stall_next = ((stall_left % 3) == 0);     // periodic
		endcase
		cal_stall <= stall_next || (long_hold_cnt != 0);
	end

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------
	// Waits until every request has gone through and the pipeline is empty.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_times.size() != 0 || time_valid || cal_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_zone(input logic signed [ZONE_W-1:0] zone);
		@(negedge clk);
		cfg_data <= zone;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		// Day and month edges, leap and non-leap century Februaries,
		// the 32-bit rollover points and both ends of the input range.
		longint corner_secs [22] = '{
			0, -1, 1, 59, 60, 3599, 3600, 86399, 86400, -86400, -86401,
			64'sd951782400,     // 2000-02-29
			64'sd951868800,     // 2000-03-01
			64'sd946684799,     // last second of 1999
			64'sd94694399,      // last second of a leap year (1972)
			-64'sd2203891200,   // 1900-03-01, century not leap
			64'sd4102444800,    // 2100-01-01
			64'sd2147483647, -64'sd2147483648,
			64'sd17179869183, -64'sd17179869184,
			-64'sd17179840385
		};
		logic signed [ZONE_W-1:0] zone_sets [7] = '{6'sd0, -6'sd24, 6'sd24,
			-6'sd32, 6'sd31, -6'sd1, 6'sd0};
		logic signed [ZONE_W-1:0] zone;
		int i, s;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed corners with the reset zone of +8 hours.
		foreach (corner_secs[i])
			pending_times.push_back(EP_W'(corner_secs[i]));
		wait_idle();

		for (s = 0; s < 7; s++) begin
			zone = (s == 6) ? ZONE_W'($urandom_range(0, 63)) : zone_sets[s];
			write_zone(zone);
			pending_times.push_back(EP_W'(-64'sd17179869184));
			pending_times.push_back(EP_W'(64'sd17179869183));
			for (i = 0; i < ITEMS_PER_SET; i++)
				pending_times.push_back(pick_epoch(zone));
			// Hold the output off while requests keep coming, so the pipeline
			// fills and pushes back on its input.
			if (s == 1 || s == 4) begin
				repeat (50) @(posedge clk);
				hold_asks++;
			end
			wait_idle();
		end

		if (cal_expected.size() != 0) begin
			mismatches++;
			$display("tb: %0d results never arrived", cal_expected.size());
		end
		$display("tb: %0d times converted under %0d zone settings, %0d results checked",
			times_sent, zone_writes + 1, results_checked);
		$display("tb: input held off by the block for %0d cycles, %0d mismatches",
			input_stall_cycles, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
